@@ hdl/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, sizes and counter helpers for the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int GS_BITS   = 13;
    localparam int BI_BITS   = 12;
    localparam int CH_BITS   = 12;
    localparam int HIST_BITS = (GS_BITS > CH_BITS) ? GS_BITS : CH_BITS;
    localparam int CLR_BITS  = (HIST_BITS > BI_BITS) ? HIST_BITS : BI_BITS;

    typedef logic [1:0] ctr_t;

    localparam ctr_t CTR_MIN  = 2'd0;
    localparam ctr_t CTR_INIT = 2'd1;
    localparam ctr_t CTR_MAX  = 2'd3;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_TRAIN   = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] branch_pc;
        logic        taken;
    } req_item_t;

    typedef struct packed {
        logic predict_taken;
        logic chose_global;
    } rsp_item_t;

    // item held between the table read and the update
    typedef struct packed {
        logic               train;
        logic               taken;
        logic [BI_BITS-1:0] bi_idx;
        logic [GS_BITS-1:0] gs_idx;
        logic [CH_BITS-1:0] ch_idx;
    } stage_t;

    typedef struct packed {
        ctr_t bi;
        ctr_t gs;
        ctr_t ch;
    } ctrs_t;

    // most recent table write, for the same-edge read bypass
    typedef struct packed {
        logic               valid;
        logic [BI_BITS-1:0] bi_idx;
        logic [GS_BITS-1:0] gs_idx;
        logic [CH_BITS-1:0] ch_idx;
        ctrs_t              ctrs;
    } last_wr_t;

    function automatic ctr_t ctr_move(input ctr_t c, input logic up);
        ctr_t r;
        r = c;
        if (up)
        begin
            if (c != CTR_MAX)
            begin
                r = c + 2'd1;
            end
        end
        else
        begin
            if (c != CTR_MIN)
            begin
                r = c - 2'd1;
            end
        end
        return r;
    endfunction

    function automatic logic ctr_high(input ctr_t c);
        return c[1];
    endfunction

endpackage

@@ hdl/tournament_branch_predictor_top.sv @@
// ----------------------------------------------------------------------------
// tournament_branch_predictor_top
// Gshare and bimodal predictors with a chooser, 2-bit counters throughout.
// ----------------------------------------------------------------------------
// After reset the block sweeps all three counter tables to their initial
// value, one entry per cycle through 2**CLR_BITS addresses (8192 at the
// default sizes), holding req_stall high meanwhile. It then takes one request
// per cycle unless the response side stalls it; the table read registers at
// the transfer edge with the request, and when that stage advances the
// prediction enters the response register and the counter update is written.
// Each table has a single write port, and a write landing on the same edge as
// the next read is bypassed from a copy of the last write.
module tournament_branch_predictor_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tbp_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tbp_pkg::rsp_item_t rsp_item
);
    import tbp_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                st_reg, st_next;
    logic [CLR_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [HIST_BITS-1:0]  hist_reg, hist_next;
    logic                  s2_valid_reg, s2_valid_next;
    stage_t                s2_reg, s2_next;
    last_wr_t              last_reg, last_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_item_t             rsp_reg, rsp_next;

    logic      accept;
    logic      s2_advance;
    logic      clearing;
    logic      tbl_wr;
    ctrs_t     rd_ctrs;
    ctrs_t     new_ctrs;
    rsp_item_t result;
    stage_t    req_stage;

    assign clearing   = (st_reg == ST_CLEAR);
    assign s2_advance = s2_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = clearing || (s2_valid_reg && !s2_advance);
    assign accept     = req_valid && !req_stall;
    assign tbl_wr     = clearing || (s2_advance && s2_reg.train);

    always_comb
    begin
        req_stage.train  = (req_item.opcode == OP_TRAIN);
        req_stage.taken  = req_item.taken;
        req_stage.bi_idx = req_item.branch_pc[BI_BITS-1:0];
        req_stage.gs_idx = req_item.branch_pc[GS_BITS-1:0] ^ hist_reg[GS_BITS-1:0];
        req_stage.ch_idx = req_item.branch_pc[CH_BITS-1:0] ^ hist_reg[CH_BITS-1:0];
    end

    tbp_ram #(.ADDR_BITS(BI_BITS)) u_bi_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (req_stage.bi_idx),
        .rd_data (rd_ctrs.bi),
        .wr_en   (tbl_wr),
        .wr_addr (clearing ? clr_cnt_reg[BI_BITS-1:0] : s2_reg.bi_idx),
        .wr_data (clearing ? CTR_INIT : new_ctrs.bi)
    );

    tbp_ram #(.ADDR_BITS(GS_BITS)) u_gs_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (req_stage.gs_idx),
        .rd_data (rd_ctrs.gs),
        .wr_en   (tbl_wr),
        .wr_addr (clearing ? clr_cnt_reg[GS_BITS-1:0] : s2_reg.gs_idx),
        .wr_data (clearing ? CTR_INIT : new_ctrs.gs)
    );

    tbp_ram #(.ADDR_BITS(CH_BITS)) u_ch_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (req_stage.ch_idx),
        .rd_data (rd_ctrs.ch),
        .wr_en   (tbl_wr),
        .wr_addr (clearing ? clr_cnt_reg[CH_BITS-1:0] : s2_reg.ch_idx),
        .wr_data (clearing ? CTR_INIT : new_ctrs.ch)
    );

    tbp_core u_core (
        .stage    (s2_reg),
        .rd_ctrs  (rd_ctrs),
        .last_wr  (last_reg),
        .result   (result),
        .new_ctrs (new_ctrs)
    );

    always_comb
    begin
        st_next        = st_reg;
        clr_cnt_next   = clr_cnt_reg;
        hist_next      = hist_reg;
        s2_valid_next  = s2_valid_reg;
        s2_next        = s2_reg;
        last_next      = last_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        unique case (st_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + {{(CLR_BITS-1){1'b0}}, 1'b1};
                if (clr_cnt_reg == {CLR_BITS{1'b1}})
                begin
                    st_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                st_next = ST_RUN;
            end
            default:
            begin
                st_next = ST_CLEAR;
            end
        endcase

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (s2_advance)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = result;
            s2_valid_next  = 1'b0;
            if (s2_reg.train)
            begin
                last_next.valid  = 1'b1;
                last_next.bi_idx = s2_reg.bi_idx;
                last_next.gs_idx = s2_reg.gs_idx;
                last_next.ch_idx = s2_reg.ch_idx;
                last_next.ctrs   = new_ctrs;
            end
        end

        // history is known at transfer time, so later items index with it at once
        if (accept)
        begin
            s2_valid_next = 1'b1;
            s2_next       = req_stage;
            if (req_stage.train)
            begin
                hist_next = {hist_reg[HIST_BITS-2:0], req_item.taken};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            hist_reg       <= '0;
            s2_valid_reg   <= 1'b0;
            last_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            clr_cnt_reg    <= clr_cnt_next;
            hist_reg       <= hist_next;
            s2_valid_reg   <= s2_valid_next;
            last_reg       <= last_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg          <= s2_next;
        rsp_reg         <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_item.opcode == OP_TRAIN) |=> (hist_reg[0] == $past(req_item.taken)))
        else $error("history did not take the trained outcome");

    a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!accept || req_item.opcode == OP_PREDICT) |=> $stable(hist_reg))
        else $error("history changed without a train transfer");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_advance) |=> (s2_valid_reg && $stable(s2_reg)))
        else $error("stalled stage item was lost or changed");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!s2_valid_reg && !rsp_valid_reg && !last_reg.valid))
        else $error("item in flight during table clear");

    a_run_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_RUN) |=> (st_reg == ST_RUN))
        else $error("table clear restarted without reset");

endmodule

@@ hdl/tbp_ram.sv @@
// ----------------------------------------------------------------------------
// tbp_ram
// Counter table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tbp_ram #(
    parameter int ADDR_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output tbp_pkg::ctr_t        rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  tbp_pkg::ctr_t        wr_data
);
    import tbp_pkg::*;

    ctr_t mem [2**ADDR_BITS];
    ctr_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the contents from before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/tbp_core.sv @@
// ----------------------------------------------------------------------------
// tbp_core
// Prediction and counter update for the item whose table reads are back.
// ----------------------------------------------------------------------------
module tbp_core (
    input  tbp_pkg::stage_t   stage,
    input  tbp_pkg::ctrs_t    rd_ctrs,
    input  tbp_pkg::last_wr_t last_wr,
    output tbp_pkg::rsp_item_t result,
    output tbp_pkg::ctrs_t    new_ctrs
);
    import tbp_pkg::*;

    ctrs_t cur;
    logic  bi_pred;
    logic  gs_pred;
    logic  use_global;
    logic  gs_ok;
    logic  bi_ok;

    // a write at the same edge as the read is not seen by the table read
    always_comb
    begin
        cur.bi = (last_wr.valid && (last_wr.bi_idx == stage.bi_idx)) ? last_wr.ctrs.bi
                                                                       : rd_ctrs.bi;
        cur.gs = (last_wr.valid && (last_wr.gs_idx == stage.gs_idx)) ? last_wr.ctrs.gs
                                                                       : rd_ctrs.gs;
        cur.ch = (last_wr.valid && (last_wr.ch_idx == stage.ch_idx)) ? last_wr.ctrs.ch
                                                                       : rd_ctrs.ch;
    end

    assign bi_pred    = ctr_high(cur.bi);
    assign gs_pred    = ctr_high(cur.gs);
    assign use_global = ctr_high(cur.ch);

    assign result.predict_taken = use_global ? gs_pred : bi_pred;
    assign result.chose_global  = use_global;

    assign gs_ok = (gs_pred == stage.taken);
    assign bi_ok = (bi_pred == stage.taken);

    always_comb
    begin
        new_ctrs.bi = ctr_move(cur.bi, stage.taken);
        new_ctrs.gs = ctr_move(cur.gs, stage.taken);
        // chooser only learns when the components disagree
        new_ctrs.ch = (gs_ok != bi_ok) ? ctr_move(cur.ch, gs_ok) : cur.ch;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tournament branch predictor: a directed table
// of requests, then 500 random requests, most drawn from a pool of branches
// with biased, alternating and correlated outcomes. Responses are checked
// against typed rows, else a model of the bimodal, gshare and chooser tables.
// ----------------------------------------------------------------------------
module tb_top;

    import tbp_pkg::*;

    localparam int DIR_N        = 20;
    localparam int RAND_ITEMS   = 500;
    localparam int QUIET_ITEMS  = 100;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 40;
    localparam int POOL_N       = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 50000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic        op;
        logic [31:0] pc;
        logic        tk;
        logic        typed;
        logic        pt;
        logic        cg;
    } dir_row_t;

    typedef struct packed {
        logic      typed;
        rsp_item_t rsp;
    } item_note_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    // predictor state
    ctr_t                 bim_ctr [1 << BI_BITS];
    ctr_t                 gsh_ctr [1 << GS_BITS];
    ctr_t                 sel_ctr [1 << CH_BITS];
    logic [HIST_BITS-1:0] ghist;

    rsp_item_t  expected_rsp [$];
    item_note_t item_notes [$];
    dir_row_t   dir_tab [DIR_N];
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;
    bit         hold_busy = 1'b0;

    tournament_branch_predictor_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ctr_t sat_step(input ctr_t c, input logic up);
        if (up)
        begin
            return (c == CTR_MAX) ? c : ctr_t'(c + 2'd1);
        end
        return (c == CTR_MIN) ? c : ctr_t'(c - 2'd1);
    endfunction

    // response from the tables as they stand, then the update for a train
    function automatic rsp_item_t predict_branch(input req_item_t rq);
        logic [BI_BITS-1:0] bi;
        logic [GS_BITS-1:0] gs;
        logic [CH_BITS-1:0] ch;
        logic               bi_t;
        logic               gs_t;
        logic               use_gs;
        rsp_item_t          r;
        bi     = rq.branch_pc[BI_BITS-1:0];
        gs     = rq.branch_pc[GS_BITS-1:0] ^ ghist[GS_BITS-1:0];
        ch     = rq.branch_pc[CH_BITS-1:0] ^ ghist[CH_BITS-1:0];
        bi_t   = bim_ctr[bi] > CTR_INIT;
        gs_t   = gsh_ctr[gs] > CTR_INIT;
        use_gs = sel_ctr[ch] > CTR_INIT;
        r.predict_taken = use_gs ? gs_t : bi_t;
        r.chose_global  = use_gs;
        if (rq.opcode == OP_TRAIN)
        begin
            // chooser only moves when exactly one component was right
            if ((gs_t == rq.taken) != (bi_t == rq.taken))
            begin
                sel_ctr[ch] = sat_step(sel_ctr[ch], gs_t == rq.taken);
            end
            gsh_ctr[gs] = sat_step(gsh_ctr[gs], rq.taken);
            bim_ctr[bi] = sat_step(bim_ctr[bi], rq.taken);
            ghist = {ghist[HIST_BITS-2:0], rq.taken};
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic want, input logic got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("%0t: %s expected %0b actual %0b", $realtime, what, want, got);
        end
    endtask

    // request and response monitor
    always @(posedge clk)
    begin
        item_note_t nt;
        rsp_item_t  p;
        rsp_item_t  e;
        if (req_valid && !req_stall)
        begin
            nt = item_notes.pop_front();
            p  = predict_branch(req_item);
            expected_rsp.push_back(nt.typed ? nt.rsp : p);
        end
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("%0t: response with none outstanding: %b", $realtime, rsp_item);
                end
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp_item.predict_taken !== e.predict_taken)
                begin
                    note_mismatch("predict_taken", e.predict_taken, rsp_item.predict_taken);
                end
                if (rsp_item.chose_global !== e.chose_global)
                begin
                    note_mismatch("chose_global", e.chose_global, rsp_item.chose_global);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // response side stalls, plus one long hold-off to back the block up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_busy = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_busy = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic offer(input req_item_t rq, input logic typed, input rsp_item_t rsp);
        item_note_t nt;
        nt.typed = typed;
        nt.rsp   = rsp;
        item_notes.push_back(nt);
        req_item  <= rq;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (!quiet && !hold_busy && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    initial
    begin
        req_item_t   rq;
        rsp_item_t   rsp;
        logic [31:0] pc_pool [POOL_N];
        logic        alt [POOL_N];
        logic        last_taken;
        int          k;

        ghist = '0;
        foreach (bim_ctr[i]) bim_ctr[i] = CTR_INIT;
        foreach (gsh_ctr[i]) gsh_ctr[i] = CTR_INIT;
        foreach (sel_ctr[i]) sel_ctr[i] = CTR_INIT;

        //              op          pc            tk    typed pt    cg
        dir_tab[0]  = '{OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0};
        // predict ignores the outcome bit
        dir_tab[1]  = '{OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0};
        dir_tab[2]  = '{OP_TRAIN,   32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0};
        dir_tab[3]  = '{OP_TRAIN,   32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0};
        // saturate up, then down, on one branch
        dir_tab[4]  = '{OP_TRAIN,   32'h0000_0040, 1'b1, 1'b0, 1'b0, 1'b0};
        dir_tab[5]  = '{OP_TRAIN,   32'h0000_0040, 1'b1, 1'b0, 1'b0, 1'b0};
        dir_tab[6]  = '{OP_TRAIN,   32'h0000_0040, 1'b1, 1'b0, 1'b0, 1'b0};
        dir_tab[7]  = '{OP_TRAIN,   32'h0000_0040, 1'b1, 1'b0, 1'b0, 1'b0};
        // same bimodal slot through the upper pc bits
        dir_tab[8]  = '{OP_PREDICT, 32'h8000_1040, 1'b0, 1'b0, 1'b0, 1'b0};
        dir_tab[9]  = '{OP_TRAIN,   32'h0000_0040, 1'b0, 1'b0, 1'b0, 1'b0};
        dir_tab[10] = '{OP_TRAIN,   32'h0000_0040, 1'b0, 1'b0, 1'b0, 1'b0};
        dir_tab[11] = '{OP_TRAIN,   32'h0000_0040, 1'b0, 1'b0, 1'b0, 1'b0};
        dir_tab[12] = '{OP_TRAIN,   32'h0000_0040, 1'b0, 1'b0, 1'b0, 1'b0};
        dir_tab[13] = '{OP_TRAIN,   32'h0000_0040, 1'b0, 1'b0, 1'b0, 1'b0};
        dir_tab[14] = '{OP_TRAIN,   32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0};
        dir_tab[15] = '{OP_TRAIN,   32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0};
        dir_tab[16] = '{OP_PREDICT, 32'h0000_1FFF, 1'b1, 1'b0, 1'b0, 1'b0};
        dir_tab[17] = '{OP_TRAIN,   32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 1'b0};
        dir_tab[18] = '{OP_TRAIN,   32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0};
        dir_tab[19] = '{OP_PREDICT, 32'h0000_0040, 1'b0, 1'b0, 1'b0, 1'b0};

        for (int i = 0; i < POOL_N; i++)
        begin
            // the last few alias earlier branches in the bimodal table
            pc_pool[i] = (i >= 12) ? (pc_pool[i - 11] ^ 32'h0000_1000) : $urandom;
            alt[i]     = 1'b0;
        end
        last_taken = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            rq.opcode            = dir_tab[i].op;
            rq.branch_pc         = dir_tab[i].pc;
            rq.taken             = dir_tab[i].tk;
            rsp.predict_taken    = dir_tab[i].pt;
            rsp.chose_global     = dir_tab[i].cg;
            offer(rq, dir_tab[i].typed, rsp);
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS - QUIET_ITEMS)
            begin
                quiet = 1'b1;
            end
            if (n == HOLD_AT)
            begin
                hold_req = 1'b1;
            end
            rq.opcode = ($urandom_range(0, 4) != 0) ? OP_TRAIN : OP_PREDICT;
            if ($urandom_range(0, 4) == 0)
            begin
                rq.branch_pc = $urandom;
                rq.taken     = 1'($urandom_range(0, 1));
            end
            else
            begin
                k = $urandom_range(0, POOL_N - 1);
                rq.branch_pc = pc_pool[k];
                case (k % 4)
                    0: rq.taken = ($urandom_range(0, 19) != 0);
                    1: rq.taken = ($urandom_range(0, 19) == 0);
                    2:
                    begin
                        alt[k]   = ~alt[k];
                        rq.taken = alt[k];
                    end
                    // follows the last trained outcome, so only history predicts it
                    default: rq.taken = last_taken;
                endcase
            end
            if (rq.opcode == OP_TRAIN)
            begin
                last_taken = rq.taken;
            end
            offer(rq, 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            mismatches += expected_rsp.size();
        end

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
